[src/lmsfir_pkg.sv]
// ----------------------------------------------------------------------------
// LMS adaptive FIR filter package
// Register indexes, reset values, fixed-point limits and saturation helpers.
// ----------------------------------------------------------------------------
package lmsfir_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int TAPS_W    = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ERROR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS_IN_USE   = 2'd2;

  localparam logic [CFG_W-1:0]          STEP_RESET = 16'd328;
  localparam logic signed [SAMPLE_W-1:0] INIT_ERR_RESET = 16'sd0;
  localparam logic [TAPS_W-1:0]         TAPS_RESET = 6'd32;

  localparam logic signed [COEF_W-1:0]   COEF_MAX = 24'sh7FFFFF;
  localparam logic signed [COEF_W-1:0]   COEF_MIN = 24'sh800000;
  localparam logic signed [SAMPLE_W-1:0] Q15_MAX  = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] Q15_MIN  = 16'sh8000;

  // Saturate a sum that carries one guard bit down to the coefficient width.
  function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [COEF_W:0] v);
    logic signed [COEF_W-1:0] r;
    if (v[COEF_W] != v[COEF_W-1]) begin
      r = v[COEF_W] ? COEF_MIN : COEF_MAX;
    end else begin
      r = v[COEF_W-1:0];
    end
    return r;
  endfunction

  // Saturate a Q1.15 sum with one guard bit.
  function automatic logic signed [SAMPLE_W-1:0] sat_q15(input logic signed [SAMPLE_W:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v[SAMPLE_W] != v[SAMPLE_W-1]) begin
      r = v[SAMPLE_W] ? Q15_MIN : Q15_MAX;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

[src/lmsfir_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lmsfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/lms_adaptive_fir_filter_top.sv]
// ----------------------------------------------------------------------------
// LMS adaptive FIR filter, top level
// Streaming adaptive FIR with delayed LMS coefficient update, one tap per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries one beat per sample:
//   sample, desired sample, a prime flag and an end-of-run flag. The output
//   channel (out_valid_o / out_ready_i) carries the filter output, the error
//   and the run_last flag. A primed beat produces no output beat.
//   Configuration registers are written through cfg_we_i / cfg_idx_i /
//   cfg_wdata_i while the block is idle; unknown indexes are ignored.
//   A normal beat keeps in_ready_o low after acceptance while the block steps
//   through the step-error product, a pass over the T taps in use, the drain
//   and the write-back, so the next beat is accepted only once it is through;
//   the result becomes valid in the output register in the same cycle that
//   in_ready_o returns. The pass runs through a single shared tap pipeline
//   (update multiply, saturating add, output multiply, accumulate) that visits
//   one tap per cycle, reading the delay line and the coefficient store from
//   one RAM port each. A primed beat goes straight to the write-back.
//   Reset clears the delay line and coefficients at once through per-entry
//   valid bits, so no clearing pass is needed. If the receiver stalls, the
//   finished result waits in the output register; the next beat is accepted
//   and processed, and only its final write-back waits for the register.
// ----------------------------------------------------------------------------
module lms_adaptive_fir_filter_top
  import lmsfir_pkg::*;
#(
  parameter int MAX_TAPS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]            cfg_wdata_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [SAMPLE_W-1:0]  sample_in_i,
  input  logic signed [SAMPLE_W-1:0]  desired_in_i,
  input  logic                        prime_i,
  input  logic                        end_of_run_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [SAMPLE_W-1:0]  filter_out_o,
  output logic signed [SAMPLE_W-1:0]  error_out_o,
  output logic                        run_last_o
);

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TW    = $clog2(MAX_TAPS + 1);
  localparam int CW    = (TW > TAPS_W) ? TW : TAPS_W;
  localparam int MUE_W = 33;
  localparam int P1_W  = MUE_W + SAMPLE_W;
  localparam int P2_W  = COEF_W + SAMPLE_W;
  localparam int ACC_W = P2_W + AW;
  localparam int UPD_SH = 26;
  localparam int OUT_SH = 20;
  localparam int YW    = ACC_W - OUT_SH;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUE   = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;

  // Configuration registers.
  logic [CFG_W-1:0]           step_q;
  logic signed [SAMPLE_W-1:0] init_err_q;
  logic [TAPS_W-1:0]          taps_q;

  // Sequencer and control state.
  logic [2:0]    state_q, state_d;
  logic [TW-1:0] t_q, t_d;
  logic [TW-1:0] iss_q, iss_d;
  logic [AW-1:0] rptr_q, rptr_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] wcnt_q, wcnt_d;
  logic          va_q, va_last_q, vb_q, vc_q, vd_q;
  logic          va_d, va_last_d, vb_d, vc_d, vd_d;
  logic [MAX_TAPS-1:0] wvld_q, wvld_d;
  logic [MAX_TAPS-1:0] cvld_q, cvld_d;
  logic          wv_rd_q, cv_rd_q;
  logic          ovalid_q, ovalid_d;
  logic signed [SAMPLE_W-1:0] last_err_q, last_err_d;

  // Item and datapath registers.
  logic signed [SAMPLE_W-1:0] s_q, d_q;
  logic                       prime_q, eor_q;
  logic signed [MUE_W-1:0]    mue_q;
  logic signed [SAMPLE_W-1:0] a1_q;
  logic signed [P1_W-1:0]     p1_q;
  logic signed [COEF_W-1:0]   c1_q;
  logic signed [COEF_W-1:0]   cn_q;
  logic signed [P2_W-1:0]     p2_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [SAMPLE_W-1:0] fo_q, eo_q;
  logic                       rl_q;

  logic                       in_acc;
  logic                       shift_go;
  logic                       out_load;
  logic [AW-1:0]              head_nxt;
  logic [AW:0]                start_off, start_sum;
  logic [AW-1:0]              craddr;
  logic [CW-1:0]              taps_ext;
  logic [SAMPLE_W-1:0]        w_rdata;
  logic [COEF_W-1:0]          c_rdata;
  logic signed [SAMPLE_W-1:0] a_sel;
  logic signed [16:0]         mu_s;
  logic signed [COEF_W:0]     upd_sum;
  logic signed [YW-1:0]       y_full;
  logic signed [SAMPLE_W-1:0] y_sat, e_sat;
  logic [YW-SAMPLE_W:0]       y_hi;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign shift_go   = (state_q == S_SHIFT) && (prime_q || !ovalid_q || out_ready_i);
  assign out_load   = shift_go && !prime_q;

  assign head_nxt  = (head_q == AW'(MAX_TAPS - 1)) ? '0 : head_q + AW'(1);
  // Oldest sample in use sits T-1 places behind the head, modulo the depth.
  assign start_off = (AW+1)'(MAX_TAPS) - (AW+1)'(t_q) + (AW+1)'(1);
  assign start_sum = (AW+1)'(head_q) + start_off;
  assign craddr    = (iss_q == t_q) ? '0 : iss_q[AW-1:0];
  assign taps_ext  = CW'(taps_q);
  assign mu_s      = {1'b0, step_q};

  // Stage A operand: the stored sample, or the new sample in the extra slot.
  always_comb begin
    if (va_last_q) begin
      a_sel = s_q;
    end else if (wv_rd_q) begin
      a_sel = $signed(w_rdata);
    end else begin
      a_sel = '0;
    end
  end

  assign upd_sum = {c1_q[COEF_W-1], c1_q}
                 + {{(COEF_W + 1 - (P1_W - UPD_SH)){p1_q[P1_W-1]}}, p1_q[P1_W-1:UPD_SH]};

  // Output and error saturation.
  assign y_full = acc_q[ACC_W-1:OUT_SH];
  assign y_hi   = y_full[YW-1:SAMPLE_W-1];
  always_comb begin
    if ((&y_hi) || !(|y_hi)) begin
      y_sat = y_full[SAMPLE_W-1:0];
    end else begin
      y_sat = y_full[YW-1] ? Q15_MIN : Q15_MAX;
    end
    e_sat = sat_q15({d_q[SAMPLE_W-1], d_q} - {y_sat[SAMPLE_W-1], y_sat});
  end

  // Delay line as a circular buffer; the head holds the newest sample.
  lmsfir_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_TAPS)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (shift_go),
    .waddr_i (head_nxt),
    .wdata_i (s_q),
    .raddr_i (rptr_q),
    .rdata_o (w_rdata)
  );

  lmsfir_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (vc_q),
    .waddr_i (wcnt_q),
    .wdata_i (cn_q),
    .raddr_i (craddr),
    .rdata_o (c_rdata)
  );

  // Sequencer next state.
  always_comb begin
    state_d    = state_q;
    t_d        = t_q;
    iss_d      = iss_q;
    rptr_d     = rptr_q;
    head_d     = head_q;
    wcnt_d     = wcnt_q;
    wvld_d     = wvld_q;
    cvld_d     = cvld_q;
    last_err_d = last_err_q;
    va_d       = 1'b0;
    va_last_d  = 1'b0;
    vb_d       = va_q && !va_last_q;
    vc_d       = vb_q;
    vd_d       = vc_q;
    ovalid_d   = ovalid_q && !out_ready_i;

    if (vc_q) begin
      wcnt_d         = wcnt_q + AW'(1);
      cvld_d[wcnt_q] = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (taps_q == '0) begin
            t_d = TW'(1);
          end else if (taps_ext > CW'(MAX_TAPS)) begin
            t_d = TW'(MAX_TAPS);
          end else begin
            t_d = TW'(taps_ext);
          end
          state_d = prime_i ? S_SHIFT : S_MUE;
        end
      end
      S_MUE: begin
        iss_d   = '0;
        wcnt_d  = '0;
        rptr_d  = (start_sum >= (AW+1)'(MAX_TAPS)) ? AW'(start_sum - (AW+1)'(MAX_TAPS))
                                                   : AW'(start_sum);
        state_d = S_RUN;
      end
      S_RUN: begin
        va_d      = 1'b1;
        va_last_d = (iss_q == t_q);
        rptr_d    = (rptr_q == AW'(MAX_TAPS - 1)) ? '0 : rptr_q + AW'(1);
        iss_d     = iss_q + TW'(1);
        if (iss_q == t_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!(va_q || vb_q || vc_q || vd_q)) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (shift_go) begin
          head_d = head_nxt;
          if (eor_q) begin
            wvld_d     = '0;
            last_err_d = init_err_q;
          end else begin
            wvld_d[head_nxt] = 1'b1;
            if (!prime_q) begin
              last_err_d = e_sat;
            end
          end
          if (out_load) begin
            ovalid_d = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      t_q        <= '0;
      iss_q      <= '0;
      rptr_q     <= '0;
      head_q     <= '0;
      wcnt_q     <= '0;
      wvld_q     <= '0;
      cvld_q     <= '0;
      wv_rd_q    <= 1'b0;
      cv_rd_q    <= 1'b0;
      va_q       <= 1'b0;
      va_last_q  <= 1'b0;
      vb_q       <= 1'b0;
      vc_q       <= 1'b0;
      vd_q       <= 1'b0;
      ovalid_q   <= 1'b0;
      last_err_q <= INIT_ERR_RESET;
      step_q     <= STEP_RESET;
      init_err_q <= INIT_ERR_RESET;
      taps_q     <= TAPS_RESET;
    end else begin
      state_q    <= state_d;
      t_q        <= t_d;
      iss_q      <= iss_d;
      rptr_q     <= rptr_d;
      head_q     <= head_d;
      wcnt_q     <= wcnt_d;
      wvld_q     <= wvld_d;
      cvld_q     <= cvld_d;
      wv_rd_q    <= wvld_q[rptr_q];
      cv_rd_q    <= cvld_q[craddr];
      va_q       <= va_d;
      va_last_q  <= va_last_d;
      vb_q       <= vb_d;
      vc_q       <= vc_d;
      vd_q       <= vd_d;
      ovalid_q   <= ovalid_d;
      last_err_q <= last_err_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_STEP_SIZE:     step_q     <= cfg_wdata_i;
          REG_INITIAL_ERROR: init_err_q <= $signed(cfg_wdata_i);
          REG_TAPS_IN_USE:   taps_q     <= cfg_wdata_i[TAPS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers: the shared tap pipeline and the output register.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_q     <= sample_in_i;
      d_q     <= desired_in_i;
      prime_q <= prime_i;
      eor_q   <= end_of_run_i;
    end
    if (state_q == S_MUE) begin
      mue_q <= mu_s * last_err_q;
      acc_q <= '0;
    end else if (vd_q) begin
      acc_q <= acc_q + ACC_W'(p2_q);
    end
    // Stage A: update product against the old window.
    if (va_q) begin
      a1_q <= a_sel;
      p1_q <= mue_q * a_sel;
      c1_q <= cv_rd_q ? $signed(c_rdata) : '0;
    end
    // Stage B: saturating coefficient update.
    if (vb_q) begin
      cn_q <= sat_coef(upd_sum);
    end
    // Stage C: output product; the sample held here is the next tap's old sample.
    if (vc_q) begin
      p2_q <= cn_q * a1_q;
    end
    if (out_load) begin
      fo_q <= y_sat;
      eo_q <= e_sat;
      rl_q <= eor_q;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign filter_out_o = fo_q;
  assign error_out_o  = eo_q;
  assign run_last_o   = rl_q;

  // Assertions.
  a_pipe_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (va_q || vb_q || vc_q || vd_q) |-> (state_q == S_RUN || state_q == S_DRAIN))
    else $error("tap pipeline active outside a pass");

  a_shift_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> !(va_q || vb_q || vc_q || vd_q))
    else $error("write-back with taps still in flight");

  a_coef_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q |-> (TW'(wcnt_q) < t_q))
    else $error("coefficient write beyond taps in use");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("ready right after accepting a beat");

endmodule

[tb/sv/lms_fir_checker.sv]
// ----------------------------------------------------------------------------
// LMS adaptive FIR filter checker
// Watches the configuration port and both streaming channels, predicts each
// filter result from its own copy of the delay line, coefficients and error,
// and compares every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module lms_fir_checker
  import lmsfir_pkg::*;
#(
  parameter int MAX_TAPS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic signed [SAMPLE_W-1:0] desired_in_i,
  input  logic                       prime_i,
  input  logic                       end_of_run_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic signed [SAMPLE_W-1:0] filter_out_i,
  input  logic signed [SAMPLE_W-1:0] error_out_i,
  input  logic                       run_last_i,
  output int                         fail_count_o,
  output int                         outstanding_o,
  output int                         compared_o
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filter_out;
    logic signed [SAMPLE_W-1:0] error_out;
    logic                       run_last;
  } filter_result_t;

  logic [CFG_W-1:0]           step_size;
  logic signed [SAMPLE_W-1:0] initial_error;
  logic [TAPS_W-1:0]          taps_in_use;

  logic signed [SAMPLE_W-1:0] delay_line [MAX_TAPS];
  logic signed [COEF_W-1:0]   coef_bank  [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] stored_error;

  filter_result_t expected_filter_q [$];
  filter_result_t want;
  filter_result_t got;
  int             errors   = 0;
  int             compared = 0;

  function automatic longint saturate_to(input longint v, input longint lo, input longint hi);
    longint r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  // Delayed LMS step: adapt with the window as it stood, shift, then filter; a primed beat only shifts.
  task automatic predict_filter_step(input logic signed [SAMPLE_W-1:0] s,
                                     input logic signed [SAMPLE_W-1:0] d,
                                     input logic primed, input logic run_end);
    int unsigned    t;
    int             j;
    longint         prod;
    longint         acc;
    longint         y;
    longint         e;
    filter_result_t r;
    t = taps_in_use;
    if (t < 1) t = 1;
    if (t > MAX_TAPS) t = MAX_TAPS;
    if (!primed) begin
      for (j = 0; j < t; j++) begin
        prod = longint'(step_size) * longint'(stored_error) * longint'(delay_line[t-1-j]);
        coef_bank[j] = COEF_W'(saturate_to(longint'(coef_bank[j]) + (prod >>> 26),
                                           longint'(COEF_MIN), longint'(COEF_MAX)));
      end
    end
    for (j = MAX_TAPS - 1; j > 0; j--) delay_line[j] = delay_line[j-1];
    delay_line[0] = s;
    if (!primed) begin
      acc = 0;
      for (j = 0; j < t; j++) acc += longint'(coef_bank[j]) * longint'(delay_line[t-1-j]);
      y = saturate_to(acc >>> 20, longint'(Q15_MIN), longint'(Q15_MAX));
      e = saturate_to(longint'(d) - y, longint'(Q15_MIN), longint'(Q15_MAX));
      stored_error = SAMPLE_W'(e);
      r.filter_out = SAMPLE_W'(y);
      r.error_out  = SAMPLE_W'(e);
      r.run_last   = run_end;
      expected_filter_q.push_back(r);
    end
    if (run_end) begin
      delay_line   = '{default: '0};
      stored_error = initial_error;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size     = STEP_RESET;
      initial_error = INIT_ERR_RESET;
      taps_in_use   = TAPS_RESET;
      delay_line    = '{default: '0};
      coef_bank     = '{default: '0};
      stored_error  = INIT_ERR_RESET;
      expected_filter_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_STEP_SIZE:     step_size     = cfg_wdata_i;
          REG_INITIAL_ERROR: initial_error = cfg_wdata_i;
          REG_TAPS_IN_USE:   taps_in_use   = cfg_wdata_i[TAPS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got.filter_out = filter_out_i;
        got.error_out  = error_out_i;
        got.run_last   = run_last_i;
        if (expected_filter_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: unexpected result beat out=%0d err=%0d last=%0b",
                     got.filter_out, got.error_out, got.run_last);
        end else begin
          want = expected_filter_q.pop_front();
          compared++;
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: result %0d (exp/got): out %0d/%0d err %0d/%0d last %0b/%0b",
                       compared, want.filter_out, got.filter_out, want.error_out,
                       got.error_out, want.run_last, got.run_last);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        predict_filter_step(sample_in_i, desired_in_i, prime_i, end_of_run_i);
    end
    fail_count_o  <= errors;
    outstanding_o <= expected_filter_q.size();
    compared_o    <= compared;
  end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// LMS adaptive FIR filter testbench
// Drives sample beats through the filter under a series of register settings
// and lets the checker compare every result; reports a single verdict.
// ----------------------------------------------------------------------------
module tb_top
  import lmsfir_pkg::*;
;

  localparam int MAX_TAPS      = 32;
  localparam int RANDOM_BEATS  = 1400;
  localparam int STALL_LIMIT   = 5000;
  // Index one past the last register; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Flavors of random run content.
  typedef enum int {
    STYLE_FULL,   // full-range samples and desired values
    STYLE_QUIET,  // small amplitudes, so adaptation stays out of saturation
    STYLE_EDGE,   // values drawn from the extremes and around zero
    STYLE_TRACK   // desired follows the previous sample at half scale
  } run_style_e;

  logic clk    = 1'b0;
  logic rst_n  = 1'b0;

  logic                       cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx   = '0;
  logic [CFG_W-1:0]           cfg_wdata = '0;

  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample    = '0;
  logic signed [SAMPLE_W-1:0] desired   = '0;
  logic                       prime     = 1'b0;
  logic                       run_end   = 1'b0;

  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] filter_out;
  logic signed [SAMPLE_W-1:0] error_out;
  logic                       run_last;

  int fail_count;
  int outstanding;
  int compared;

  // When set, neither side inserts idle cycles.
  logic calm = 1'b0;

  int beats    = 0;
  int primed   = 0;
  int run_ends = 0;
  int settings = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  lms_adaptive_fir_filter_top #(.MAX_TAPS(MAX_TAPS)) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .sample_in_i  (sample),
    .desired_in_i (desired),
    .prime_i      (prime),
    .end_of_run_i (run_end),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .filter_out_o (filter_out),
    .error_out_o  (error_out),
    .run_last_o   (run_last)
  );

  lms_fir_checker #(.MAX_TAPS(MAX_TAPS)) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .sample_in_i   (sample),
    .desired_in_i  (desired),
    .prime_i       (prime),
    .end_of_run_i  (run_end),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .filter_out_i  (filter_out),
    .error_out_i   (error_out),
    .run_last_i    (run_last),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .compared_o    (compared)
  );

  // The receiver stalls in roughly one cycle out of five, except in the calm phase.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 20);
  end

  // Watchdog: a long stretch with no beat on either channel means the block hung
  // or a prediction was never matched by a result.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d results still expected",
                 quiet_cycles, outstanding);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Present one input beat and hold it until the block accepts it. Valid is only
  // dropped while the sender idles, so it is never lowered and raised in one step.
  task automatic feed_beat(input logic signed [SAMPLE_W-1:0] s,
                           input logic signed [SAMPLE_W-1:0] d,
                           input logic p, input logic e);
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    desired  <= d;
    prime    <= p;
    run_end  <= e;
    do @(posedge clk); while (!in_ready);
    beats++;
    if (p) primed++;
    if (e) run_ends++;
  endtask

  // Let every expected result come back, then give a trailing primed beat time
  // to finish, since it produces nothing to wait for.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (MAX_TAPS + 16) @(posedge clk);
  endtask

  // Write all registers back to back, starting with a stray write to the
  // unused index, which the block must ignore.
  task automatic apply_setting(input logic [CFG_W-1:0] step,
                               input logic [CFG_W-1:0] init_err,
                               input logic [TAPS_W-1:0] taps);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_UNUSED;
    cfg_wdata <= CFG_W'($urandom);
    @(posedge clk);
    cfg_idx   <= REG_STEP_SIZE;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_idx   <= REG_INITIAL_ERROR;
    cfg_wdata <= init_err;
    @(posedge clk);
    cfg_idx   <= REG_TAPS_IN_USE;
    cfg_wdata <= CFG_W'(taps);
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_value(input run_style_e style);
    logic signed [SAMPLE_W-1:0] v;
    case (style)
      STYLE_QUIET: v = SAMPLE_W'($urandom_range(0, 4096) - 2048);
      STYLE_EDGE: begin
        case ($urandom_range(0, 4))
          0:       v = Q15_MAX;
          1:       v = Q15_MIN;
          2:       v = 16'sd1;
          3:       v = -16'sd1;
          default: v = '0;
        endcase
      end
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  // One run: up to three primed beats to fill the delay line, a body of normal beats,
  // and usually an end of run. Some runs are left open so they merge with the
  // next, some close on a primed beat, and an occasional stray beat with random
  // flags goes in front.
  task automatic send_run();
    run_style_e                 style;
    int                         n_lead;
    int                         n_body;
    int                         k;
    logic                       closed;
    logic                       prime_close;
    logic signed [SAMPLE_W-1:0] s;
    logic signed [SAMPLE_W-1:0] d;
    logic signed [SAMPLE_W-1:0] prev_s;
    style       = run_style_e'($urandom_range(0, 3));
    n_lead      = $urandom_range(0, 3);
    n_body      = $urandom_range(3, 40);
    closed      = ($urandom_range(0, 9) != 0);
    prime_close = closed && ($urandom_range(0, 7) == 0);
    prev_s      = '0;
    if ($urandom_range(0, 9) == 0)
      feed_beat(SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    for (k = 0; k < n_lead; k++) begin
      s = pick_value(style);
      feed_beat(s, pick_value(style), 1'b1, 1'b0);
      prev_s = s;
    end
    for (k = 0; k < n_body; k++) begin
      s = pick_value(style);
      d = (style == STYLE_TRACK) ? (prev_s >>> 1) : pick_value(style);
      feed_beat(s, d, 1'b0, closed && !prime_close && (k == n_body - 1));
      prev_s = s;
    end
    if (prime_close) feed_beat(pick_value(style), pick_value(style), 1'b1, 1'b1);
  endtask

  initial begin
    int target;
    int phase_start;
    int setting_no;
    logic [CFG_W-1:0]  step;
    logic [CFG_W-1:0]  init_err;
    logic [TAPS_W-1:0] taps;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset settings: primed beats, extreme samples and desired
    // values, an end of run on a normal beat, then a primed beat that also ends
    // a run, which must clear the line without producing a result.
    feed_beat(Q15_MAX, '0, 1'b1, 1'b0);
    feed_beat(Q15_MIN, '0, 1'b1, 1'b0);
    feed_beat(Q15_MAX, Q15_MIN, 1'b0, 1'b0);
    feed_beat(Q15_MIN, Q15_MAX, 1'b0, 1'b0);
    feed_beat('0, '0, 1'b0, 1'b0);
    feed_beat(Q15_MAX, Q15_MAX, 1'b0, 1'b1);
    feed_beat(Q15_MIN, Q15_MIN, 1'b1, 1'b1);
    feed_beat(16'sd12345, -16'sd1000, 1'b0, 1'b0);
    settle();

    // Largest step with a single tap: a full-scale error drives the coefficient
    // by about one per beat, so the output and the error both hit their limits.
    // The new initial error only takes effect at the end of this run.
    apply_setting(16'hFFFF, Q15_MIN, 6'd1);
    feed_beat(Q15_MAX, Q15_MAX, 1'b0, 1'b0);
    feed_beat(Q15_MAX, Q15_MAX, 1'b0, 1'b0);
    feed_beat(Q15_MIN, Q15_MAX, 1'b0, 1'b0);
    feed_beat(Q15_MAX, Q15_MIN, 1'b0, 1'b0);
    feed_beat(Q15_MIN, Q15_MIN, 1'b0, 1'b0);
    feed_beat(16'sd1, -16'sd1, 1'b0, 1'b1);
    feed_beat(Q15_MAX, '0, 1'b0, 1'b0);
    settle();

    // Zero taps behaves as one, and a zero step freezes the coefficients.
    apply_setting(16'h0000, Q15_MAX, 6'd0);
    feed_beat(Q15_MIN, Q15_MAX, 1'b0, 1'b0);
    feed_beat(Q15_MAX, Q15_MIN, 1'b0, 1'b1);
    feed_beat(16'sd100, 16'sd200, 1'b0, 1'b0);
    settle();

    // A tap count above the built depth behaves as the full depth.
    apply_setting(16'hFFFF, 16'h0000, 6'd63);
    feed_beat(Q15_MAX, Q15_MAX, 1'b0, 1'b0);
    feed_beat(Q15_MIN, Q15_MIN, 1'b0, 1'b0);
    feed_beat(16'sh5555, 16'shAAAA, 1'b0, 1'b0);
    feed_beat(16'shAAAA, 16'sh5555, 1'b0, 1'b1);
    settle();

    // Random part: a new register setting every ~180 beats, cycling through the
    // extremes of step size and tap count, with one phase free of idle cycles.
    target     = beats + RANDOM_BEATS;
    setting_no = 0;
    while (beats < target) begin
      case (setting_no % 8)
        0:       begin step = 16'hFFFF;                          taps = 6'd32; end
        1:       begin step = 16'h0000;                          taps = 6'd1;  end
        2:       begin step = CFG_W'($urandom);                  taps = 6'd0;  end
        3:       begin step = CFG_W'($urandom_range(1, 2000));   taps = 6'd63; end
        4:       begin step = CFG_W'($urandom_range(100, 4000)); taps = 6'd2;  end
        default: begin
          step = CFG_W'($urandom);
          taps = TAPS_W'($urandom_range(0, 63));
        end
      endcase
      case (setting_no % 8)
        0:       init_err = Q15_MIN;
        1:       init_err = Q15_MAX;
        default: init_err = CFG_W'($urandom);
      endcase
      calm <= (setting_no == 3);
      apply_setting(step, init_err, taps);
      phase_start = beats;
      while (beats < target && beats - phase_start < 180) send_run();
      settle();
      setting_no++;
    end

    $display("Covered %0d input beats (%0d primed, %0d run ends) under %0d register settings.",
             beats, primed, run_ends, settings);
    $display("Compared %0d results; settings spanned step 0 to 65535 and taps 0 to 63.",
             compared);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
